FILE: rtl/sdre_pkg.sv
// ----------------------------------------------------------------------------
// sdre_pkg
// Shared types and constants for the sensor poll decoder and event ring.
// ----------------------------------------------------------------------------
package sdre_pkg;

	localparam int BANK_COUNT_DEF = 5;
	localparam int RING_DEPTH_DEF = 10;

	localparam int CODE_W  = 7;
	localparam int FIELD_W = 4;

	typedef enum logic [1:0] {
		ACT_POLL = 2'd0,
		ACT_BYTE = 2'd1,
		ACT_READ = 2'd2
	} action_t;

	localparam logic KIND_EVENT = 1'b0;
	localparam logic KIND_READ  = 1'b1;

	// one result word as it leaves the block
	typedef struct packed {
		logic               kind;
		logic [CODE_W-1:0]  code;
		logic [FIELD_W-1:0] slot;
		logic [FIELD_W-1:0] count;
		logic [FIELD_W-1:0] head;
		logic               last;
	} res_t;

endpackage

FILE: rtl/sdre_ring.sv
// ----------------------------------------------------------------------------
// sdre_ring
// Ring store of recent event codes: one write port, one registered read port.
// Per-entry valid bits make unwritten entries read as zero after reset.
// ----------------------------------------------------------------------------
module sdre_ring
	import sdre_pkg::*;
#(
	parameter int RING_DEPTH = RING_DEPTH_DEF,
	localparam int IW = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              wr_en,
	input  logic [IW-1:0]     wr_addr,
	input  logic [CODE_W-1:0] wr_data,
	input  logic              rd_en,
	input  logic              rd_ok,
	input  logic [IW-1:0]     rd_addr,
	output logic [CODE_W-1:0] rd_data
);

	logic [CODE_W-1:0]   mem [RING_DEPTH];
	logic [RING_DEPTH-1:0] vld_q;
	logic [CODE_W-1:0]   rd_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (wr_en) begin
			vld_q[wr_addr] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// out-of-range slots and never-written entries read as zero
	always_ff @(posedge clk) begin
		if (rd_en) begin
			if (rd_ok && vld_q[rd_addr]) begin
				rd_data_q <= mem[rd_addr];
			end else begin
				rd_data_q <= '0;
			end
		end
	end

	assign rd_data = rd_data_q;

endmodule

FILE: rtl/sdre_scan.sv
// ----------------------------------------------------------------------------
// sdre_scan
// Takes input words, scans poll bytes MSB first, one set bit per cycle while
// out_free; keeps byte counter, ring head, count, newest code; drives ring.
// ----------------------------------------------------------------------------
module sdre_scan
	import sdre_pkg::*;
#(
	parameter int BANK_COUNT = BANK_COUNT_DEF,
	parameter int RING_DEPTH = RING_DEPTH_DEF,
	localparam int IW = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               item_valid,
	output logic               item_ready,
	input  logic [1:0]         action,
	input  logic [7:0]         sensor_byte,
	input  logic [FIELD_W-1:0] slot_index,
	input  logic               out_free,
	output logic               res_load,
	output res_t               res,
	output logic               wr_en,
	output logic [IW-1:0]      wr_addr,
	output logic [CODE_W-1:0]  wr_data,
	output logic               rd_en,
	output logic               rd_ok,
	output logic [IW-1:0]      rd_addr
);

	localparam int POLL_LEN = 2 * BANK_COUNT;
	localparam int CW = $clog2(POLL_LEN + 1);
	localparam int NW = $clog2(RING_DEPTH + 1);

	logic [CW-1:0]      bcnt_q;
	logic [IW-1:0]      head_q;
	logic [NW-1:0]      cnt_q;
	logic [CODE_W-1:0]  newest_q;

	logic               job_vld_q;
	logic               job_rd_q;
	logic [7:0]         mask_q;
	logic [3:0]         bank_q;
	logic               pos_q;
	logic               first_q;
	logic [FIELD_W-1:0] idx_q;

	logic               accept;
	logic               byte_ok;
	logic               job_new;
	logic               step;
	logic               job_done;
	logic [2:0]         k_sel;
	logic [7:0]         mask_rem;
	logic [CODE_W-1:0]  code;
	logic               dup;
	logic               append;
	logic [IW-1:0]      head_nx;
	logic [NW-1:0]      cnt_nx;
	logic [6:0]         idx_ext;
	logic [CW-1:0]      half;

	// highest set bit first
	always_comb begin
		k_sel = 3'd0;
		for (int k = 7; k >= 0; k--) begin
			if (mask_q[7-k]) begin
				k_sel = 3'(k);
			end
		end
	end

	assign mask_rem = mask_q & ~(8'h80 >> k_sel);
	assign code     = CODE_W'({bank_q, pos_q, k_sel});
	// within one byte codes differ, so only the first set bit can repeat
	assign dup      = first_q && (code == newest_q);

	assign step     = job_vld_q && out_free;
	assign job_done = job_rd_q || (mask_rem == 8'd0);
	assign append   = step && !job_rd_q && !dup;

	assign item_ready = !job_vld_q || (step && job_done);
	assign accept     = item_valid && item_ready;

	assign byte_ok = bcnt_q < CW'(POLL_LEN);
	assign job_new = accept && ((action_t'(action) == ACT_READ)
		|| ((action_t'(action) == ACT_BYTE) && byte_ok && (sensor_byte != 8'd0)));

	assign head_nx = (head_q == IW'(RING_DEPTH - 1)) ? '0 : head_q + IW'(1);
	assign cnt_nx  = (cnt_q == NW'(RING_DEPTH)) ? cnt_q : cnt_q + NW'(1);

	assign idx_ext = 7'(idx_q);
	assign half    = bcnt_q >> 1;

	assign wr_en   = append;
	assign wr_addr = head_q;
	assign wr_data = code;
	assign rd_en   = step && job_rd_q;
	assign rd_ok   = idx_ext < 7'(RING_DEPTH);
	assign rd_addr = idx_ext[IW-1:0];

	assign res_load = append || rd_en;

	always_comb begin
		if (job_rd_q) begin
			res.kind  = KIND_READ;
			res.code  = '0;
			res.slot  = idx_q;
			res.count = FIELD_W'(cnt_q);
			res.head  = FIELD_W'(head_q);
			res.last  = 1'b1;
		end else begin
			res.kind  = KIND_EVENT;
			res.code  = code;
			res.slot  = FIELD_W'(head_q);
			res.count = FIELD_W'(cnt_nx);
			res.head  = FIELD_W'(head_nx);
			res.last  = (mask_rem == 8'd0);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q   <= '0;
			cnt_q    <= '0;
			newest_q <= '0;
		end else if (append) begin
			head_q   <= head_nx;
			cnt_q    <= cnt_nx;
			newest_q <= code;
		end
	end

	// a new job may start in the cycle the previous one finishes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			job_vld_q <= 1'b0;
			job_rd_q  <= 1'b0;
			first_q   <= 1'b0;
		end else if (job_new) begin
			job_vld_q <= 1'b1;
			job_rd_q  <= (action_t'(action) == ACT_READ);
			first_q   <= 1'b1;
		end else if (step && job_done) begin
			job_vld_q <= 1'b0;
		end else if (step) begin
			first_q <= 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bcnt_q <= CW'(POLL_LEN);
		end else if (accept) begin
			case (action_t'(action))
				ACT_POLL: begin
					bcnt_q <= '0;
				end
				ACT_BYTE: begin
					if (byte_ok) begin
						bcnt_q <= bcnt_q + CW'(1);
					end
				end
				default: begin
				end
			endcase
		end
	end

	// payload of the job in hand
	always_ff @(posedge clk) begin
		if (accept) begin
			mask_q <= sensor_byte;
			bank_q <= 4'(half + CW'(1));
			pos_q  <= bcnt_q[0];
			idx_q  <= slot_index;
		end else if (step) begin
			mask_q <= mask_rem;
		end
	end

endmodule

FILE: rtl/sensor_dump_recent_events_core.sv
// ----------------------------------------------------------------------------
// sensor_dump_recent_events_core
// Poll reply decoder feeding a ring of recent sensor event codes.
// ----------------------------------------------------------------------------
// Input channel item_valid/item_ready carries action, sensor_byte, slot_index.
// start_poll arms the byte counter and produces nothing. Each poll byte (up to
// two per bank) is scanned MSB first; every set bit whose code differs from
// the newest ring entry is appended and reported as one result word.
// read_slot gives one word with the slot contents, ring head and count.
// Output channel result_valid/result_ready carries kind, event_code, slot,
// entry_count, head and last (set on the final word of an input word).
// Results leave from an output register; a first set bit that repeats the
// newest entry is scanned but gives no word. The scanner takes one set bit
// per cycle, MSB first, while the output register is free; start_poll and
// ignored words do not hold it. A new word is taken in the cycle the
// scanner finishes, so words run back to back.
// If the receiver stalls, the output register holds and the scanner waits.
// Reset clears the ring (valid bits), head, count and disarms the poll.
// ----------------------------------------------------------------------------
module sensor_dump_recent_events_core
	import sdre_pkg::*;
#(
	parameter int BANK_COUNT = BANK_COUNT_DEF,
	parameter int RING_DEPTH = RING_DEPTH_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               item_valid,
	output logic               item_ready,
	input  logic [1:0]         action,
	input  logic [7:0]         sensor_byte,
	input  logic [FIELD_W-1:0] slot_index,
	output logic               result_valid,
	input  logic               result_ready,
	output logic               kind,
	output logic [CODE_W-1:0]  event_code,
	output logic [FIELD_W-1:0] slot,
	output logic [FIELD_W-1:0] entry_count,
	output logic [FIELD_W-1:0] head,
	output logic               last
);

	localparam int IW = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;

	logic              out_free;
	logic              res_load;
	res_t              res;
	logic              wr_en;
	logic [IW-1:0]     wr_addr;
	logic [CODE_W-1:0] wr_data;
	logic              rd_en;
	logic              rd_ok;
	logic [IW-1:0]     rd_addr;
	logic [CODE_W-1:0] rd_data;

	logic              res_vld_s1;
	res_t              res_s1;

	sdre_scan #(
		.BANK_COUNT (BANK_COUNT),
		.RING_DEPTH (RING_DEPTH)
	) u_scan (
		.clk         (clk),
		.arst_n      (arst_n),
		.item_valid  (item_valid),
		.item_ready  (item_ready),
		.action      (action),
		.sensor_byte (sensor_byte),
		.slot_index  (slot_index),
		.out_free    (out_free),
		.res_load    (res_load),
		.res         (res),
		.wr_en       (wr_en),
		.wr_addr     (wr_addr),
		.wr_data     (wr_data),
		.rd_en       (rd_en),
		.rd_ok       (rd_ok),
		.rd_addr     (rd_addr)
	);

	sdre_ring #(
		.RING_DEPTH (RING_DEPTH)
	) u_ring (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_ok   (rd_ok),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	assign out_free = !res_vld_s1 || result_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_vld_s1 <= 1'b0;
		end else if (res_load) begin
			res_vld_s1 <= 1'b1;
		end else if (result_ready) begin
			res_vld_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_load) begin
			res_s1 <= res;
		end
	end

	// read replies take their code from the ring's read register,
	// loaded in the same cycle as res_s1
	assign result_valid = res_vld_s1;
	assign kind         = res_s1.kind;
	assign event_code   = (res_s1.kind == KIND_READ) ? rd_data : res_s1.code;
	assign slot         = res_s1.slot;
	assign entry_count  = res_s1.count;
	assign head         = res_s1.head;
	assign last         = res_s1.last;

endmodule

FILE: rtl/sdre_chk.sv
// ----------------------------------------------------------------------------
// sdre_chk
// Port-level checks on the result channel of the event ring block.
// ----------------------------------------------------------------------------
module sdre_chk
	import sdre_pkg::*;
(
	input logic               clk,
	input logic               arst_n,
	input logic               result_valid,
	input logic               result_ready,
	input logic               kind,
	input logic [CODE_W-1:0]  event_code,
	input logic [FIELD_W-1:0] entry_count,
	input logic               last
);

	// a stalled word holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(event_code)
			&& $stable(kind) && $stable(last))
		else $error("result word changed while stalled");

	// a read reply is always the only word of its item
	a_read_last: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && (kind == KIND_READ) |-> last)
		else $error("read reply without last");

	// after an append the ring cannot be empty
	a_append_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && (kind == KIND_EVENT) |-> entry_count != '0)
		else $error("append reported with empty ring");

endmodule

bind sensor_dump_recent_events_core sdre_chk u_sdre_chk (
	.clk          (clk),
	.arst_n       (arst_n),
	.result_valid (result_valid),
	.result_ready (result_ready),
	.kind         (kind),
	.event_code   (event_code),
	.entry_count  (entry_count),
	.last         (last)
);
